>>> rtl/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg: shared types and constants of the Huffman tree bit decoder
// Field widths, result kinds, opcodes and the controller/datapath buses.
// ----------------------------------------------------------------------------
package htbd_pkg;

   // Defaults of the top-level parameters
   localparam int MaxNodesDefault   = 512;
   localparam int MaxCodeLenDefault = 16;

   // Fixed field widths of the request and response transactions
   localparam int SymBits     = 8;
   localparam int CodeBits    = 16;
   localparam int LenBits     = 5;
   localparam int CodeIdxBits = 5;
   localparam int CodeExtBits = 32;

   // Opcodes of a request
   localparam logic OpInsert = 1'b0;
   localparam logic OpDecode = 1'b1;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_SYMBOL  = 2'd0,
      KIND_MISSING = 2'd1,
      KIND_FULL    = 2'd2
   } kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic     load;       // latch the accepted request
      logic     rd_walk;    // read the insert walk node
      logic     ins_step;   // follow or create a child on one code bit
      logic     ins_leaf;   // write the leaf entry
      logic     rd_cur;     // read the current decode node
      logic     dec_step;   // follow a child on the coded bit
      logic     dec_chk;    // settle on the child just read
      logic     emit;       // load the result register
      kind_type emit_kind;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic len_zero;
      logic last_bit;
      logic ins_has_child;
      logic table_full;
      logic cache_valid;
      logic dec_has_child;
      logic child_internal;
      logic child_has_sym;
   } status_type;

endpackage

>>> rtl/htbd_if.sv
// ----------------------------------------------------------------------------
// htbd_if: request and response channels of the Huffman tree bit decoder
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface htbd_req_if;
   import htbd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [SymBits-1:0]     symbol_in;
   logic [CodeBits-1:0]    code_bits;
   logic [LenBits-1:0]     code_length;
   logic                   data_bit;

   modport source (output valid, output opcode, output symbol_in, output code_bits,
                   output code_length, output data_bit, input ready);
   modport sink   (input valid, input opcode, input symbol_in, input code_bits,
                   input code_length, input data_bit, output ready);
endinterface

interface htbd_rsp_if;
   import htbd_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [SymBits-1:0] symbol_out;

   modport source (output valid, output kind, output symbol_out, input ready);
   modport sink   (input valid, input kind, input symbol_out, output ready);
endinterface

>>> rtl/htbd_datapath.sv
// ----------------------------------------------------------------------------
// htbd_datapath: node table, walk registers and result register
// Executes controller commands on the code tree held in a single-port memory.
// ----------------------------------------------------------------------------
module htbd_datapath #(
   parameter int MAX_NODES    = htbd_pkg::MaxNodesDefault,
   parameter int MAX_CODE_LEN = htbd_pkg::MaxCodeLenDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  htbd_pkg::cmd_type             cmd,
   output htbd_pkg::status_type          status,
   input  logic                          req_opcode,
   input  logic [htbd_pkg::SymBits-1:0]  req_symbol_in,
   input  logic [htbd_pkg::CodeBits-1:0] req_code_bits,
   input  logic [htbd_pkg::LenBits-1:0]  req_code_length,
   input  logic                          req_data_bit,
   output htbd_pkg::kind_type            rsp_kind,
   output logic [htbd_pkg::SymBits-1:0]  rsp_symbol_out
);
   import htbd_pkg::*;

   localparam int NodeBits = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int UsedBits = $clog2(MAX_NODES + 1);
   localparam int CntBits  = $clog2(MAX_CODE_LEN + 1);

   typedef struct packed {
      logic [NodeBits-1:0] left;
      logic [NodeBits-1:0] right;
      logic                has_left;
      logic                has_right;
      logic [SymBits-1:0]  sym;
      logic                has_sym;
   } entry_type;

   // Node table
   entry_type mem [MAX_NODES];

   // Request and walk registers
   logic [SymBits-1:0]  sym_ff;
   logic [CodeBits-1:0] code_ff;
   logic                data_bit_ff;
   logic [CntBits-1:0]  bit_idx_ff;
   logic [NodeBits-1:0] node_ff;
   logic                fresh_ff;
   entry_type           rd_q_ff;
   logic                rd_zero_ff;
   entry_type           cache_ff;
   kind_type            kind_ff;
   logic [SymBits-1:0]  sym_out_ff;

   // Control registers
   logic [UsedBits-1:0] used_ff;
   logic                root_valid_ff;
   logic [NodeBits-1:0] cur_ff;
   logic                cache_valid_ff;

   // Combinational
   logic [LenBits:0]        len_wide;
   logic [CntBits-1:0]      len_clamp;
   logic [CodeExtBits-1:0]  code_ext;
   logic [CodeIdxBits-1:0]  bit_sel;
   logic                    code_bit;
   entry_type               eff_rd;
   entry_type               ent_cur;
   entry_type               ins_upd;
   entry_type               leaf_ent;
   logic                    ins_has;
   logic [NodeBits-1:0]     ins_child;
   logic [NodeBits-1:0]     new_idx;
   logic                    full;
   logic                    dec_has;
   logic [NodeBits-1:0]     dec_child;
   logic                    wr_en;
   logic [NodeBits-1:0]     wr_addr;
   entry_type               wr_data;
   logic                    rd_en;
   logic [NodeBits-1:0]     rd_addr;
   logic                    rd_force;
   logic                    rd_zero_in;

   // Clamp the code length to the longest supported code
   always_comb begin
      len_wide = {1'b0, req_code_length};
      if (len_wide > (LenBits + 1)'(MAX_CODE_LEN)) begin
         len_clamp = CntBits'(MAX_CODE_LEN);
      end else begin
         len_clamp = CntBits'(len_wide);
      end
   end

   // Select the code bit of this step; bits above the code field read as zero
   assign code_ext = {{(CodeExtBits - CodeBits){1'b0}}, code_ff};
   assign bit_sel  = CodeIdxBits'(CntBits'(bit_idx_ff - CntBits'(1)));
   assign code_bit = code_ext[bit_sel];

   // Entry as read; a never-written root or a fresh node reads empty
   assign eff_rd  = rd_zero_ff ? '0 : rd_q_ff;
   assign ent_cur = cache_valid_ff ? cache_ff : eff_rd;

   // Insert step decisions
   assign full      = (used_ff == UsedBits'(MAX_NODES));
   assign new_idx   = NodeBits'(used_ff);
   assign ins_has   = code_bit ? eff_rd.has_right : eff_rd.has_left;
   assign ins_child = code_bit ? eff_rd.right : eff_rd.left;

   always_comb begin
      ins_upd = eff_rd;
      if (code_bit) begin
         ins_upd.right     = new_idx;
         ins_upd.has_right = 1'b1;
      end else begin
         ins_upd.left     = new_idx;
         ins_upd.has_left = 1'b1;
      end
   end

   always_comb begin
      leaf_ent         = '0;
      leaf_ent.sym     = sym_ff;
      leaf_ent.has_sym = 1'b1;
   end

   // Decode step decisions
   assign dec_has   = data_bit_ff ? ent_cur.has_right : ent_cur.has_left;
   assign dec_child = data_bit_ff ? ent_cur.right : ent_cur.left;

   // Memory port control
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = node_ff;
      wr_data  = leaf_ent;
      rd_en    = 1'b0;
      rd_addr  = node_ff;
      rd_force = 1'b0;
      if (cmd.ins_step && !ins_has) begin
         wr_en   = 1'b1;
         wr_data = full ? eff_rd : ins_upd;
      end
      if (cmd.ins_leaf) begin
         wr_en = 1'b1;
      end
      if (cmd.rd_walk) begin
         rd_en    = 1'b1;
         rd_force = fresh_ff;
      end
      if (cmd.rd_cur) begin
         rd_en   = 1'b1;
         rd_addr = cur_ff;
      end
      if (cmd.dec_step && dec_has) begin
         rd_en   = 1'b1;
         rd_addr = dec_child;
      end
   end

   assign rd_zero_in = rd_force || ((rd_addr == '0) && !root_valid_ff);

   // Node table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff    <= mem[rd_addr];
         rd_zero_ff <= rd_zero_in;
      end
   end

   // Control state: fill count, root mark, current node, cache mark
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= UsedBits'(1);
         root_valid_ff  <= 1'b0;
         cur_ff         <= '0;
         cache_valid_ff <= 1'b0;
      end else begin
         if (wr_en && (wr_addr == '0)) begin
            root_valid_ff <= 1'b1;
         end
         if (cmd.load && (req_opcode == OpInsert)) begin
            cur_ff         <= '0;
            cache_valid_ff <= 1'b0;
         end
         if (cmd.ins_step && !ins_has && !full) begin
            used_ff <= used_ff + UsedBits'(1);
         end
         if (cmd.dec_step && !dec_has) begin
            cur_ff         <= '0;
            cache_valid_ff <= 1'b0;
         end
         if (cmd.dec_chk) begin
            if (eff_rd.has_left || eff_rd.has_right) begin
               cur_ff         <= node_ff;
               cache_valid_ff <= 1'b1;
            end else begin
               cur_ff         <= '0;
               cache_valid_ff <= 1'b0;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sym_ff      <= req_symbol_in;
         code_ff     <= req_code_bits;
         data_bit_ff <= req_data_bit;
         bit_idx_ff  <= len_clamp;
         node_ff     <= '0;
         fresh_ff    <= 1'b0;
      end
      if (cmd.ins_step) begin
         bit_idx_ff <= bit_idx_ff - CntBits'(1);
         if (ins_has) begin
            node_ff  <= ins_child;
            fresh_ff <= 1'b0;
         end else if (!full) begin
            node_ff  <= new_idx;
            fresh_ff <= 1'b1;
         end
      end
      if (cmd.dec_step && dec_has) begin
         node_ff <= dec_child;
      end
      if (cmd.dec_chk && (eff_rd.has_left || eff_rd.has_right)) begin
         cache_ff <= eff_rd;
      end
      if (cmd.emit) begin
         kind_ff    <= cmd.emit_kind;
         sym_out_ff <= (cmd.emit_kind == KIND_SYMBOL) ? eff_rd.sym : '0;
      end
   end

   // Status to the controller
   always_comb begin
      status.len_zero       = (bit_idx_ff == '0);
      status.last_bit       = (bit_idx_ff == CntBits'(1));
      status.ins_has_child  = ins_has;
      status.table_full     = full;
      status.cache_valid    = cache_valid_ff;
      status.dec_has_child  = dec_has;
      status.child_internal = eff_rd.has_left || eff_rd.has_right;
      status.child_has_sym  = eff_rd.has_sym;
   end

   assign rsp_kind       = kind_ff;
   assign rsp_symbol_out = sym_out_ff;

endmodule

>>> rtl/htbd_ctrl.sv
// ----------------------------------------------------------------------------
// htbd_ctrl: sequencer of the Huffman tree bit decoder
// Steps inserts bit by bit, steps decodes one node, owns the response valid.
// ----------------------------------------------------------------------------
module htbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output htbd_pkg::cmd_type    cmd,
   input  htbd_pkg::status_type status
);
   import htbd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WALK,
      ST_INS_LEAF,
      ST_DEC_RD,
      ST_DEC_STEP,
      ST_DEC_CHK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Result register can take a new transaction when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.emit_kind = KIND_SYMBOL;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_opcode == OpInsert) begin
                  state_in = ST_INS_RD;
               end else if (status.cache_valid) begin
                  state_in = ST_DEC_STEP;
               end else begin
                  state_in = ST_DEC_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (status.len_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_walk = 1'b1;
               state_in    = ST_INS_WALK;
            end
         end
         ST_INS_WALK: begin
            if (!status.ins_has_child && status.table_full) begin
               // Table full: report and drop the rest of the code
               if (slot_free) begin
                  cmd.ins_step  = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_FULL;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.ins_step = 1'b1;
               state_in     = status.last_bit ? ST_INS_LEAF : ST_INS_RD;
            end
         end
         ST_INS_LEAF: begin
            cmd.ins_leaf = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DEC_RD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_DEC_STEP;
         end
         ST_DEC_STEP: begin
            if (!status.dec_has_child) begin
               if (slot_free) begin
                  cmd.dec_step  = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_MISSING;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.dec_step = 1'b1;
               state_in     = ST_DEC_CHK;
            end
         end
         ST_DEC_CHK: begin
            if (status.child_internal) begin
               cmd.dec_chk = 1'b1;
               state_in    = ST_IDLE;
            end else if (slot_free) begin
               cmd.dec_chk   = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = status.child_has_sym ? KIND_SYMBOL : KIND_MISSING;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold a result until taken, load a new one on emit
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/huffman_tree_bit_decoder_core.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_core: Huffman code tree builder and bit decoder
// Insert transactions build the tree; decode transactions walk it one bit.
// ----------------------------------------------------------------------------
// Decode: a step on the data bit and, unless the child is missing, a check; the current
//   node is first reread from the node table when uncached (at the root after a result or an insert).
// Insert: each code bit costs one node-table read and, where the child is missing, one update
//   on the single port, plus one leaf write; a zero length writes no leaf, a full table ends the walk.
// Results leave through a register in the cycle after the deciding step; a stalled
//   result holds the walk. Reset is synchronous; the table reads empty at once.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_core #(
   parameter int MAX_NODES    = htbd_pkg::MaxNodesDefault,
   parameter int MAX_CODE_LEN = htbd_pkg::MaxCodeLenDefault
) (
   input  logic        clock,
   input  logic        reset,
   htbd_req_if.sink    req_chan,
   htbd_rsp_if.source  rsp_chan
);
   import htbd_pkg::*;

   cmd_type            cmd;
   status_type         status;
   kind_type           kind;
   logic [SymBits-1:0] symbol_out;

   // Sequencer
   htbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_opcode (req_chan.opcode),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   // Node table and walk datapath
   htbd_datapath #(
      .MAX_NODES    (MAX_NODES),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_chan.opcode),
      .req_symbol_in   (req_chan.symbol_in),
      .req_code_bits   (req_chan.code_bits),
      .req_code_length (req_chan.code_length),
      .req_data_bit    (req_chan.data_bit),
      .rsp_kind        (kind),
      .rsp_symbol_out  (symbol_out)
   );

   assign rsp_chan.kind       = kind;
   assign rsp_chan.symbol_out = symbol_out;

endmodule

>>> rtl/htbd_checker.sv
// ----------------------------------------------------------------------------
// htbd_checker: port-level checks of the Huffman tree bit decoder
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module htbd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_opcode,
   input logic [htbd_pkg::LenBits-1:0] req_code_length,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_kind,
   input logic [htbd_pkg::SymBits-1:0] rsp_symbol_out
);
   import htbd_pkg::*;

   // A stalled response transaction stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Error results carry a zero symbol
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_SYMBOL) |-> (rsp_symbol_out == '0))
      else $error("error result with nonzero symbol");

   // Every accepted request keeps the block busy in the next cycle
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted request");

   // An insert with code bits keeps the block busy into its table walk
   a_ins_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OpInsert) && (req_code_length != '0)
      |=> ##1 !req_ready)
      else $error("insert finished without a table walk");

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind huffman_tree_bit_decoder_core htbd_checker u_htbd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_opcode      (req_chan.opcode),
   .req_code_length (req_chan.code_length),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_symbol_out  (rsp_chan.symbol_out)
);
